FILE: sv/dps_pkg.sv
// Shared constants, types and helper functions of the dynamic priority scheduler.
`timescale 1ns / 1ps

package dps_pkg;

  // Table geometry and field widths
  localparam int DEPTH         = 16;
  localparam int TIME_BITS     = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int IDX_W         = $clog2(DEPTH);
  localparam int CNT_W         = $clog2(DEPTH + 1);
  localparam int SUM_W         = CNT_W + 1;

  // Priority limits, wide form for clamping and narrow form for saturation
  localparam longint PRI_MIN = -(longint'(1) << (PRIORITY_BITS - 1));
  localparam longint PRI_MAX = (longint'(1) << (PRIORITY_BITS - 1)) - 1;
  localparam logic signed [PRIORITY_BITS-1:0] PRI_MIN_P = PRIORITY_BITS'(PRI_MIN);

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_FULL     = 3'd1,
    ST_ZERO     = 3'd2,
    ST_RAN      = 3'd3,
    ST_FINISHED = 3'd4,
    ST_IDLE     = 3'd5
  } status_e;

  // One table entry
  typedef struct packed {
    logic [7:0]                      id;
    logic signed [PRIORITY_BITS-1:0] pri;
    logic [TIME_BITS-1:0]            need;
    logic [TIME_BITS-1:0]            run;
  } task_t;

  localparam int TASK_W = $bits(task_t);

  // Advance a ring index by one place
  function automatic logic [IDX_W-1:0] idx_inc(logic [IDX_W-1:0] a);
    return (a == IDX_W'(DEPTH - 1)) ? '0 : a + IDX_W'(1);
  endfunction

  // Step a ring index back by one place
  function automatic logic [IDX_W-1:0] idx_dec(logic [IDX_W-1:0] a);
    return (a == '0) ? IDX_W'(DEPTH - 1) : a - IDX_W'(1);
  endfunction

  // Ring index of the place k entries after h (k below DEPTH)
  function automatic logic [IDX_W-1:0] idx_add(logic [IDX_W-1:0] h, logic [CNT_W-1:0] k);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(h) + SUM_W'(k);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return IDX_W'(sum);
  endfunction

  // Clamp an 8-bit signed input priority into the table's priority range
  function automatic logic signed [PRIORITY_BITS-1:0] pri_from_in(logic [7:0] p);
    longint x;
    x = longint'(signed'(p));
    if (x < PRI_MIN) begin
      x = PRI_MIN;
    end
    if (x > PRI_MAX) begin
      x = PRI_MAX;
    end
    return PRIORITY_BITS'(x);
  endfunction

  // Low 8 bits of a sign-extended table priority
  function automatic logic [7:0] pri_to_out(logic signed [PRIORITY_BITS-1:0] p);
    longint x;
    x = longint'(p);
    return 8'(x);
  endfunction

endpackage

FILE: sv/dps_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module dps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write on request, register the read every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/dynamic_priority_scheduler.sv
// Top level: ring-ordered task table in RAM with an insertion-sort sequencer.
// Add: an accept into an empty table, a rejected add and an idle tick give their result
//   beat straight from the accept; other adds walk back from the tail, moving entries up.
// Tick: reads the head first; the beat follows once the task finishes or is the only one
//   held, else the task is inserted again into the remaining entries; results cannot be held off.
// One item at a time, busy until its beat shows; reset clears count and head at once.
`timescale 1ns / 1ps

module dynamic_priority_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        opcode_i,
  input  logic [7:0]  task_id_i,
  input  logic [7:0]  task_priority_i,
  input  logic [15:0] slices_needed_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [7:0]  ran_id_o,
  output logic [7:0]  ran_priority_o,
  output logic [15:0] ran_slices_o,
  output logic [4:0]  occupancy_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_HEAD,
    S_SCAN,
    S_WRITE
  } state_e;

  state_e                         state_q, state_d;
  logic [dps_pkg::IDX_W-1:0]      head_q, head_d;
  logic [dps_pkg::CNT_W-1:0]      count_q, count_d;
  logic [dps_pkg::IDX_W-1:0]      idx_q, idx_d;
  logic [dps_pkg::CNT_W-1:0]      left_q, left_d;
  dps_pkg::task_t                 cur_q, cur_d;
  dps_pkg::status_e               pend_q, pend_d;
  logic                           done_q, done_d;
  dps_pkg::status_e               status_q, status_d;
  logic [7:0]                     ran_id_q, ran_id_d;
  logic [7:0]                     ran_pri_q, ran_pri_d;
  logic [15:0]                    ran_sl_q, ran_sl_d;
  logic [4:0]                     occ_q, occ_d;

  logic                           ram_we;
  logic [dps_pkg::IDX_W-1:0]      ram_waddr;
  dps_pkg::task_t                 ram_wdata;
  logic [dps_pkg::IDX_W-1:0]      ram_raddr;
  logic [dps_pkg::TASK_W-1:0]     ram_rdata_raw;
  dps_pkg::task_t                 ram_rdata;

  dps_ram #(
    .WIDTH (dps_pkg::TASK_W),
    .DEPTH (dps_pkg::DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = dps_pkg::task_t'(ram_rdata_raw);

  // Sequencer: accept, read head, walk back from the tail moving entries up
  always_comb begin
    logic                      fin;
    dps_pkg::status_e          fin_st;
    logic                      fin_ran;
    dps_pkg::task_t            fin_task;
    logic                      ins;
    dps_pkg::task_t            ins_task;
    logic [dps_pkg::IDX_W-1:0] ins_head;
    logic [dps_pkg::CNT_W-1:0] ins_left;
    logic [dps_pkg::IDX_W-1:0] tail;
    dps_pkg::task_t            t;
    dps_pkg::task_t            nt;

    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    idx_d     = idx_q;
    left_d    = left_q;
    cur_d     = cur_q;
    pend_d    = pend_q;
    done_d    = 1'b0;
    status_d  = status_q;
    ran_id_d  = ran_id_q;
    ran_pri_d = ran_pri_q;
    ran_sl_d  = ran_sl_q;
    occ_d     = occ_q;

    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = cur_q;
    ram_raddr = dps_pkg::idx_dec(idx_q);

    fin      = 1'b0;
    fin_st   = pend_q;
    fin_ran  = 1'b0;
    fin_task = cur_q;
    ins      = 1'b0;
    ins_task = cur_q;
    ins_head = head_q;
    ins_left = count_q;
    tail     = '0;

    // New task built from the input beat
    nt.id   = task_id_i;
    nt.pri  = dps_pkg::pri_from_in(task_priority_i);
    nt.need = dps_pkg::TIME_BITS'(slices_needed_i);
    nt.run  = '0;

    // Head task after one slice
    t = ram_rdata;
    if (t.pri != dps_pkg::PRI_MIN_P) begin
      t.pri = t.pri - dps_pkg::PRIORITY_BITS'(1);
    end
    t.run = t.run + dps_pkg::TIME_BITS'(1);

    case (state_q)
      S_IDLE: begin
        ram_raddr = head_q;
        if (start) begin
          if (opcode_i == dps_pkg::OP_TICK) begin
            if (count_q == '0) begin
              fin    = 1'b1;
              fin_st = dps_pkg::ST_IDLE;
            end else begin
              state_d = S_HEAD;
            end
          end else if (nt.need == '0) begin
            fin    = 1'b1;
            fin_st = dps_pkg::ST_ZERO;
          end else if (count_q == dps_pkg::CNT_W'(dps_pkg::DEPTH)) begin
            fin    = 1'b1;
            fin_st = dps_pkg::ST_FULL;
          end else begin
            ins      = 1'b1;
            ins_task = nt;
            ins_head = head_q;
            ins_left = count_q;
            pend_d   = dps_pkg::ST_ADDED;
          end
        end
      end
      S_HEAD: begin
        head_d = dps_pkg::idx_inc(head_q);
        if (t.run == t.need) begin
          count_d  = count_q - dps_pkg::CNT_W'(1);
          fin      = 1'b1;
          fin_st   = dps_pkg::ST_FINISHED;
          fin_ran  = 1'b1;
          fin_task = t;
        end else begin
          ins      = 1'b1;
          ins_task = t;
          ins_head = head_d;
          ins_left = count_q - dps_pkg::CNT_W'(1);
          pend_d   = dps_pkg::ST_RAN;
        end
      end
      S_SCAN: begin
        ram_we = 1'b1;
        if (ram_rdata.pri <= cur_q.pri) begin
          // Move the lower or equal entry up one place and keep walking
          ram_waddr = idx_q;
          ram_wdata = ram_rdata;
          idx_d     = dps_pkg::idx_dec(idx_q);
          left_d    = left_q - dps_pkg::CNT_W'(1);
          ram_raddr = dps_pkg::idx_dec(idx_d);
          if (left_q == dps_pkg::CNT_W'(1)) begin
            state_d = S_WRITE;
          end
        end else begin
          // Drop the task in behind the strictly higher entry
          fin     = 1'b1;
          fin_ran = (pend_q == dps_pkg::ST_RAN);
        end
      end
      S_WRITE: begin
        ram_we  = 1'b1;
        fin     = 1'b1;
        fin_ran = (pend_q == dps_pkg::ST_RAN);
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Start an insertion at the tail of the ring
    if (ins) begin
      tail    = dps_pkg::idx_add(ins_head, ins_left);
      count_d = ins_left + dps_pkg::CNT_W'(1);
      cur_d   = ins_task;
      if (ins_left == '0) begin
        ram_we    = 1'b1;
        ram_waddr = tail;
        ram_wdata = ins_task;
        fin       = 1'b1;
        fin_st    = pend_d;
        fin_ran   = (pend_d == dps_pkg::ST_RAN);
        fin_task  = ins_task;
      end else begin
        ram_raddr = dps_pkg::idx_dec(tail);
        idx_d     = tail;
        left_d    = ins_left;
        state_d   = S_SCAN;
      end
    end

    // Load the result beat
    if (fin) begin
      state_d   = S_IDLE;
      done_d    = 1'b1;
      status_d  = fin_st;
      ran_id_d  = fin_ran ? fin_task.id : 8'd0;
      ran_pri_d = fin_ran ? dps_pkg::pri_to_out(fin_task.pri) : 8'd0;
      ran_sl_d  = fin_ran ? 16'(fin_task.run) : 16'd0;
      occ_d     = 5'(count_d);
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      count_q   <= '0;
      idx_q     <= '0;
      left_q    <= '0;
      pend_q    <= dps_pkg::ST_ADDED;
      done_q    <= 1'b0;
      status_q  <= dps_pkg::ST_ADDED;
      ran_id_q  <= '0;
      ran_pri_q <= '0;
      ran_sl_q  <= '0;
      occ_q     <= '0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      left_q    <= left_d;
      pend_q    <= pend_d;
      done_q    <= done_d;
      status_q  <= status_d;
      ran_id_q  <= ran_id_d;
      ran_pri_q <= ran_pri_d;
      ran_sl_q  <= ran_sl_d;
      occ_q     <= occ_d;
    end
  end

  // Task being placed needs no reset
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign ran_id_o       = ran_id_q;
  assign ran_priority_o = ran_pri_q;
  assign ran_slices_o   = ran_sl_q;
  assign occupancy_o    = occ_q;

endmodule

FILE: tb/sv/tb.sv
// Self-checking bench for the dynamic priority scheduler: table-driven and random beats.
`timescale 1ns / 1ps

module tb;
  import dps_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BEATS = 700;
  localparam int CALM_TAIL    = 100;
  localparam int SEGMENT_LEN  = 40;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int DIR_ROWS     = 27;

  // One task as the scheduler holds it
  typedef struct {
    logic [7:0]                      id;
    logic signed [PRIORITY_BITS-1:0] prio;
    logic [TIME_BITS-1:0]            need;
    logic [TIME_BITS-1:0]            run;
  } sched_task_t;

  // One result beat
  typedef struct packed {
    status_e     status;
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] slices;
    logic [4:0]  occupancy;
  } sched_result_t;

  // One row of the directed table; res is used only where typed is set
  typedef struct packed {
    opcode_e       op;
    logic [7:0]    id;
    logic [7:0]    prio;
    logic [15:0]   need;
    logic          typed;
    sched_result_t res;
  } dir_row_t;

  localparam sched_result_t NO_RESULT = '{ST_ADDED, 8'h00, 8'h00, 16'h0000, 5'd0};

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        start           = 1'b0;
  logic        busy;
  logic        opcode_i        = OP_ADD;
  logic [7:0]  task_id_i       = 8'h00;
  logic [7:0]  task_priority_i = 8'h00;
  logic [15:0] slices_needed_i = 16'h0000;
  logic        done_o;
  logic [2:0]  status_o;
  logic [7:0]  ran_id_o;
  logic [7:0]  ran_priority_o;
  logic [15:0] ran_slices_o;
  logic [4:0]  occupancy_o;

  sched_task_t   sched_tbl[$];
  sched_result_t result_q[$];
  dir_row_t      dir_rows [DIR_ROWS];
  int            fail_cnt  = 0;
  int            cycle_cnt = 0;

  dynamic_priority_scheduler dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .opcode_i        (opcode_i),
    .task_id_i       (task_id_i),
    .task_priority_i (task_priority_i),
    .slices_needed_i (slices_needed_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .ran_id_o        (ran_id_o),
    .ran_priority_o  (ran_priority_o),
    .ran_slices_o    (ran_slices_o),
    .occupancy_o     (occupancy_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Count cycles and stop a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Print one mismatch line and count it
  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_cnt++;
  endtask

  // Insert after every strictly higher priority, ahead of equal ones
  function automatic void place_task(input sched_task_t t);
    int pos;
    pos = 0;
    while (pos < sched_tbl.size() && t.prio < sched_tbl[pos].prio) pos++;
    sched_tbl.insert(pos, t);
  endfunction

  // Work out the result of one beat and advance the task table
  function automatic sched_result_t schedule_step(input opcode_e op, input logic [7:0] id,
                                                  input logic [7:0] prio,
                                                  input logic [15:0] need);
    sched_result_t res;
    sched_task_t   t;
    res = NO_RESULT;
    if (op == OP_ADD) begin
      if (need == '0) begin
        res.status = ST_ZERO;
      end else if (sched_tbl.size() >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        t = '{id, signed'(prio), need, '0};
        place_task(t);
        res.status = ST_ADDED;
      end
    end else if (sched_tbl.size() == 0) begin
      res.status = ST_IDLE;
    end else begin
      t = sched_tbl.pop_front();
      // Saturate at the lowest priority
      if (t.prio != PRI_MIN_P) t.prio = t.prio - 1'b1;
      t.run = t.run + 1'b1;
      res.id     = t.id;
      res.prio   = t.prio;
      res.slices = t.run;
      if (t.run == t.need) begin
        res.status = ST_FINISHED;
      end else begin
        place_task(t);
        res.status = ST_RAN;
      end
    end
    res.occupancy = 5'(sched_tbl.size());
    return res;
  endfunction

  // Present one beat, hold it until taken, then queue what it should produce
  task automatic issue_item(input opcode_e op, input logic [7:0] id, input logic [7:0] prio,
                            input logic [15:0] need, input logic typed,
                            input sched_result_t typed_res);
    sched_result_t res;
    start           <= 1'b1;
    opcode_i        <= op;
    task_id_i       <= id;
    task_priority_i <= prio;
    slices_needed_i <= need;
    do @(posedge clk_i); while (busy);
    res = schedule_step(op, id, prio, need);
    result_q.push_back(typed ? typed_res : res);
  endtask

  // Check each result beat against the oldest expectation
  always @(posedge clk_i) begin : result_check
    sched_result_t want;
    if (rst_ni && done_o) begin
      if (result_q.size() == 0) begin
        report_mismatch($sformatf("result with none expected, status %0d", status_o));
      end else begin
        want = result_q.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status_o, want.status));
        if (ran_id_o !== want.id)
          report_mismatch($sformatf("ran_id %0d, want %0d", ran_id_o, want.id));
        if (ran_priority_o !== want.prio)
          report_mismatch($sformatf("ran_priority %0d, want %0d",
                                    $signed(ran_priority_o), $signed(want.prio)));
        if (ran_slices_o !== want.slices)
          report_mismatch($sformatf("ran_slices %0d, want %0d", ran_slices_o, want.slices));
        if (occupancy_o !== want.occupancy)
          report_mismatch($sformatf("occupancy %0d, want %0d", occupancy_o, want.occupancy));
      end
    end
  end

  // Stimulus
  initial begin
    int          n;
    int          r;
    int          add_pct;
    int          long_cnt;
    bit          idle_on;
    opcode_e     op;
    logic [7:0]  id;
    logic [7:0]  prio;
    logic [15:0] need;

    // Directed table: empty tick, zero need, saturation, equal priorities, fill, full
    dir_rows[0]  = '{OP_TICK, 8'h00, 8'h00, 16'h0000, 1'b1,
                     '{ST_IDLE, 8'h00, 8'h00, 16'h0000, 5'd0}};
    dir_rows[1]  = '{OP_ADD,  8'hFF, 8'h7F, 16'h0000, 1'b1,
                     '{ST_ZERO, 8'h00, 8'h00, 16'h0000, 5'd0}};
    dir_rows[2]  = '{OP_ADD,  8'h00, 8'h80, 16'h0001, 1'b0, NO_RESULT};
    dir_rows[3]  = '{OP_TICK, 8'hFF, 8'hFF, 16'hFFFF, 1'b0, NO_RESULT};
    dir_rows[4]  = '{OP_ADD,  8'hFF, 8'h7F, 16'hFFFF, 1'b0, NO_RESULT};
    dir_rows[5]  = '{OP_ADD,  8'h5A, 8'h7F, 16'h0002, 1'b0, NO_RESULT};
    dir_rows[6]  = '{OP_ADD,  8'hA5, 8'h80, 16'h0003, 1'b0, NO_RESULT};
    dir_rows[7]  = '{OP_TICK, 8'h00, 8'h00, 16'h0000, 1'b0, NO_RESULT};
    dir_rows[8]  = '{OP_TICK, 8'h00, 8'h00, 16'h0000, 1'b0, NO_RESULT};
    dir_rows[9]  = '{OP_TICK, 8'h00, 8'h00, 16'h0000, 1'b0, NO_RESULT};
    dir_rows[10] = '{OP_ADD,  8'h10, 8'h00, 16'h0001, 1'b0, NO_RESULT};
    dir_rows[11] = '{OP_ADD,  8'h11, 8'hFF, 16'h0002, 1'b0, NO_RESULT};
    dir_rows[12] = '{OP_ADD,  8'h12, 8'h01, 16'h0003, 1'b0, NO_RESULT};
    dir_rows[13] = '{OP_ADD,  8'h13, 8'h7F, 16'h0001, 1'b0, NO_RESULT};
    dir_rows[14] = '{OP_ADD,  8'h14, 8'h80, 16'h0002, 1'b0, NO_RESULT};
    dir_rows[15] = '{OP_ADD,  8'h15, 8'h40, 16'h8000, 1'b0, NO_RESULT};
    dir_rows[16] = '{OP_ADD,  8'h16, 8'hC0, 16'h0004, 1'b0, NO_RESULT};
    dir_rows[17] = '{OP_ADD,  8'h17, 8'h00, 16'h0002, 1'b0, NO_RESULT};
    dir_rows[18] = '{OP_ADD,  8'h18, 8'h00, 16'h0001, 1'b0, NO_RESULT};
    dir_rows[19] = '{OP_ADD,  8'h19, 8'h05, 16'h0005, 1'b0, NO_RESULT};
    dir_rows[20] = '{OP_ADD,  8'h1A, 8'hFB, 16'h0003, 1'b0, NO_RESULT};
    dir_rows[21] = '{OP_ADD,  8'h1B, 8'h7F, 16'h0002, 1'b0, NO_RESULT};
    dir_rows[22] = '{OP_ADD,  8'h1C, 8'h80, 16'h0001, 1'b0, NO_RESULT};
    dir_rows[23] = '{OP_ADD,  8'h1D, 8'h80, 16'h0004, 1'b0, NO_RESULT};
    dir_rows[24] = '{OP_ADD,  8'hEE, 8'h7F, 16'h0001, 1'b1,
                     '{ST_FULL, 8'h00, 8'h00, 16'h0000, 5'd16}};
    dir_rows[25] = '{OP_ADD,  8'h00, 8'h80, 16'h0000, 1'b1,
                     '{ST_ZERO, 8'h00, 8'h00, 16'h0000, 5'd16}};
    dir_rows[26] = '{OP_TICK, 8'h00, 8'h00, 16'h0000, 1'b0, NO_RESULT};

    // Hold reset, then release it on an edge
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table back to back
    foreach (dir_rows[i])
      issue_item(dir_rows[i].op, dir_rows[i].id, dir_rows[i].prio, dir_rows[i].need,
                 dir_rows[i].typed, dir_rows[i].res);

    // Random beats in segments of differing add/tick mix and idling
    add_pct = 50;
    idle_on = 1'b0;
    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (n % SEGMENT_LEN == 0) begin
        r = $urandom_range(0, 3);
        add_pct = (r == 0) ? 25 : (r == 1) ? 50 : (r == 2) ? 75 : 90;
        idle_on = ($urandom_range(0, 2) != 0) && (n < RANDOM_BEATS - CALM_TAIL);
      end

      // Drop start for a burst of idle cycles now and then
      if (idle_on && $urandom_range(0, 2) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end

      op = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_TICK;
      id = 8'($urandom_range(0, 255));

      // Favour the extremes and a narrow band so that equal priorities meet
      r = $urandom_range(0, 99);
      if (r < 15)      prio = 8'h7F;
      else if (r < 30) prio = 8'h80;
      else if (r < 60) prio = 8'($urandom_range(0, 4)) - 8'd2;
      else             prio = 8'($urandom_range(0, 255));

      // Keep only a few long tasks held so the table still drains
      long_cnt = 0;
      foreach (sched_tbl[k]) if (sched_tbl[k].need > 16'd64) long_cnt++;
      r = $urandom_range(0, 99);
      if (r < 4)                          need = 16'h0000;
      else if (r < 8 && long_cnt < 3)     need = 16'($urandom_range(0, 65535));
      else if (r < 10 && long_cnt < 3)    need = 16'hFFFF;
      else                                need = 16'($urandom_range(1, 6));

      issue_item(op, id, prio, need, 1'b0, NO_RESULT);
    end
    start <= 1'b0;

    // Drain, then allow the block to settle
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (result_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", result_q.size()));

    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
